// ===== hw/rtl/tilt_complementary_filter_assert.svh =====
// Assertion macros for the tilt complementary filter RTL.
// Included by the top level; needs nothing else.
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define TCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcf assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcf assertion failed");
`else
`define TCF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/tcf_pkg.sv =====
// Shared constants and the CORDIC arctangent table for the tilt filter.
// No dependencies; used by tcf_cordic and tilt_complementary_filter.
package tcf_pkg;

	// Field widths of the sample and result transactions.
	localparam int IN_W      = 16;
	localparam int DT_W      = 17;
	localparam int ACC_OUT_W = 25;
	localparam int FUSED_W   = 28;

	// Defaults for the top-level parameters.
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// CORDIC datapath: degrees with TAB_FRAC fractional bits in the angle accumulator.
	localparam int TAB_FRAC    = 24;
	localparam int TAB_LEN     = 24;
	localparam int TAB_IDX_W   = 5;
	localparam int TAB_W       = 30;
	localparam int PRESCALE_SH = 14;
	localparam int XY_W        = IN_W + PRESCALE_SH + 3;
	localparam int Z_W         = TAB_FRAC + 9;
	localparam int ANGLE_INT_W = 9;

	// Constant divisors and the fusion weight (0.98 = 49/50).
	localparam int GYRO_DEN   = 131000000;
	localparam int FUSE_DEN   = 50;
	localparam int FUSE_GAIN  = 49;
	localparam int GYRO_DIGIT = 2;
	localparam int FUSE_DIGIT = 4;

	// atan(2^-i) in degrees, 24 fractional bits, rounded to nearest.
	function automatic logic [TAB_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			5'd0:    v = 30'd754974720;
			5'd1:    v = 30'd445687602;
			5'd2:    v = 30'd235489088;
			5'd3:    v = 30'd119537938;
			5'd4:    v = 30'd60000934;
			5'd5:    v = 30'd30029717;
			5'd6:    v = 30'd15018523;
			5'd7:    v = 30'd7509720;
			5'd8:    v = 30'd3754917;
			5'd9:    v = 30'd1877466;
			5'd10:   v = 30'd938734;
			5'd11:   v = 30'd469367;
			5'd12:   v = 30'd234684;
			5'd13:   v = 30'd117342;
			5'd14:   v = 30'd58671;
			5'd15:   v = 30'd29335;
			5'd16:   v = 30'd14668;
			5'd17:   v = 30'd7334;
			5'd18:   v = 30'd3667;
			5'd19:   v = 30'd1833;
			5'd20:   v = 30'd917;
			5'd21:   v = 30'd458;
			5'd22:   v = 30'd229;
			5'd23:   v = 30'd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/tilt_complementary_filter.sv =====
// Channel  | signals                                   | transfer
// ---------+-------------------------------------------+-----------------------
// in       | accel_x accel_z gyro_y step_time_us       | in_valid && in_ready
// out      | accel_pitch fused_pitch                   | out_valid && out_ready
//
// From acceptance to a loaded result a sample passes through the CORDIC loop (one rotation per
// cycle) and then the 4-bit-per-cycle fusion divider; the gyro divider runs alongside the CORDIC.
// The next sample is taken in the cycle after the result loads, so the block holds one sample
// at a time. A stalled output holds the block before its next result, not before the next input.
// Reset clears the pitch estimate to zero.
// Top level of the tilt complementary filter; depends on tcf_pkg, tcf_cordic, tcf_cdiv and the assertion header.
`include "tilt_complementary_filter_assert.svh"
module tilt_complementary_filter #(
	parameter int FRAC_BITS    = tcf_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tcf_pkg::IN_W-1:0]        accel_x,
	input  logic signed [tcf_pkg::IN_W-1:0]        accel_z,
	input  logic signed [tcf_pkg::IN_W-1:0]        gyro_y,
	input  logic        [tcf_pkg::DT_W-1:0]        step_time_us,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tcf_pkg::ACC_OUT_W-1:0]   accel_pitch,
	output logic signed [tcf_pkg::FUSED_W-1:0]     fused_pitch
);

	localparam int IN_W    = tcf_pkg::IN_W;
	localparam int FUSED_W = tcf_pkg::FUSED_W;
	localparam int ACC_W   = FRAC_BITS + tcf_pkg::ANGLE_INT_W;
	localparam int PROD_W  = IN_W + tcf_pkg::DT_W;
	localparam int GNUM_W  = PROD_W + FRAC_BITS;

	// Gyro increment divider sizing.
	localparam int G_DB    = tcf_pkg::GYRO_DIGIT;
	localparam int G_DLOG  = $clog2(tcf_pkg::GYRO_DEN + 1) - 1;
	localparam int G_STEPS = (GNUM_W + 1 - G_DLOG + G_DB - 1) / G_DB;
	localparam int INC_W   = G_STEPS * G_DB + 1;

	// Fusion divider sizing.
	localparam int SUM_W   = ((FUSED_W > INC_W) ? FUSED_W : INC_W) + 1;
	localparam int FS_W    = SUM_W + 7;
	localparam int F_DB    = tcf_pkg::FUSE_DIGIT;
	localparam int F_DLOG  = $clog2(tcf_pkg::FUSE_DEN + 1) - 1;
	localparam int F_STEPS = (FS_W + 1 - F_DLOG + F_DB - 1) / F_DB;
	localparam int FQ_W    = F_STEPS * F_DB + 1;

	localparam logic signed [FQ_W-1:0]  F_MAX   = FQ_W'((64'sd1 <<< (FUSED_W - 1)) - 64'sd1);
	localparam logic signed [FQ_W-1:0]  F_MIN   = -F_MAX - FQ_W'(1);
	localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(180 * (2 ** FRAC_BITS));

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_SCALE = 3'd3;
	localparam logic [2:0] S_FDIV  = 3'd4;
	localparam logic [2:0] S_FWAIT = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]                state_q;
	logic                      acc_have_q, inc_have_q;
	logic                      out_valid_q;
	logic signed [FUSED_W-1:0] pitch_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [INC_W-1:0]   inc_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [FS_W-1:0]    fnum_q;
	logic signed [tcf_pkg::ACC_OUT_W-1:0] acc_out_q;
	logic signed [FUSED_W-1:0] fused_out_q;

	logic                      in_fire, out_load;
	logic                      cdone, gdone, fdone;
	logic signed [ACC_W-1:0]   cangle;
	logic signed [INC_W-1:0]   ginc;
	logic signed [FQ_W-1:0]    fquo, fsat;
	logic signed [PROD_W:0]    prod_full;
	logic signed [GNUM_W-1:0]  gnum;
	logic signed [SUM_W-1:0]   sum_nx;
	logic signed [FS_W-1:0]    fnum_nx;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign prod_full = gyro_y * $signed({1'b0, step_time_us});
	assign gnum      = {prod_q, {FRAC_BITS{1'b0}}};
	assign sum_nx    = pitch_q + inc_q;
	assign fnum_nx   = sum_q * FS_W'(tcf_pkg::FUSE_GAIN) + acc_q;

	always_comb begin
		if (fquo > F_MAX) begin
			fsat = F_MAX;
		end else if (fquo < F_MIN) begin
			fsat = F_MIN;
		end else begin
			fsat = fquo;
		end
	end

	tcf_cordic #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.ax     (accel_x),
		.az     (accel_z),
		.done   (cdone),
		.angle  (cangle)
	);

	tcf_cdiv #(
		.NUM_W      (GNUM_W),
		.DIVISOR    (tcf_pkg::GYRO_DEN),
		.DIGIT_BITS (G_DB),
		.STEPS      (G_STEPS)
	) u_gdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_MUL),
		.num    (gnum),
		.done   (gdone),
		.quo    (ginc)
	);

	tcf_cdiv #(
		.NUM_W      (FS_W),
		.DIVISOR    (tcf_pkg::FUSE_DEN),
		.DIGIT_BITS (F_DB),
		.STEPS      (F_STEPS)
	) u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_FDIV),
		.num    (fnum_q),
		.done   (fdone),
		.quo    (fquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_have_q  <= 1'b0;
			inc_have_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pitch_q     <= '0;
		end else begin
			if (cdone) begin
				acc_have_q <= 1'b1;
			end
			if (gdone) begin
				inc_have_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_WAIT;
				S_WAIT: begin
					if (acc_have_q && inc_have_q) begin
						acc_have_q <= 1'b0;
						inc_have_q <= 1'b0;
						state_q    <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_FDIV;
				S_FDIV:  state_q <= S_FWAIT;
				S_FWAIT: begin
					if (fdone) begin
						pitch_q <= FUSED_W'(fsat);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_q <= prod_full[PROD_W-1:0];
		end
		if (cdone) begin
			acc_q <= cangle;
		end
		if (gdone) begin
			inc_q <= ginc;
		end
		if (state_q == S_WAIT && acc_have_q && inc_have_q) begin
			sum_q <= sum_nx;
		end
		if (state_q == S_SCALE) begin
			fnum_q <= fnum_nx;
		end
		if (out_load) begin
			acc_out_q   <= tcf_pkg::ACC_OUT_W'(acc_q);
			fused_out_q <= pitch_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign accel_pitch = acc_out_q;
	assign fused_pitch = fused_out_q;

	`TCF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_fire, !in_ready)
	`TCF_ASSERT_NOW(a_units_done_in_wait, clk, arst_n, cdone || gdone, state_q == S_WAIT)
	`TCF_ASSERT_NOW(a_acc_in_range, clk, arst_n, acc_have_q, (acc_q <= ACC_LIM) && (acc_q >= -ACC_LIM))
	`TCF_ASSERT_NEXT(a_out_matches_state, clk, arst_n, out_load, fused_pitch == pitch_q)

endmodule

// ===== hw/rtl/tcf_cordic.sv =====
// Iterative vectoring CORDIC: atan2(-ax, az) in degrees, one rotation per cycle.
// Depends on tcf_pkg for widths and the arctangent table.
module tcf_cordic #(
	parameter int FRAC_BITS    = tcf_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic signed [tcf_pkg::IN_W-1:0]            ax,
	input  logic signed [tcf_pkg::IN_W-1:0]            az,
	output logic                                       done,
	output logic signed [FRAC_BITS+tcf_pkg::ANGLE_INT_W-1:0] angle
);

	localparam int XY_W      = tcf_pkg::XY_W;
	localparam int Z_W       = tcf_pkg::Z_W;
	localparam int ACC_W     = FRAC_BITS + tcf_pkg::ANGLE_INT_W;
	localparam int STEPS_EFF = (CORDIC_STEPS > tcf_pkg::TAB_LEN) ? tcf_pkg::TAB_LEN
	                                                             : CORDIC_STEPS;
	localparam int CNT_W     = $clog2(STEPS_EFF);
	localparam int SH_OUT    = tcf_pkg::TAB_FRAC - FRAC_BITS;
	localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(2 ** (SH_OUT - 1));
	localparam logic signed [Z_W-1:0] Z_LIM   = Z_W'(180 * (2 ** FRAC_BITS));
	localparam logic signed [Z_W-1:0] Z_QUAD  = Z_W'(90 * (2 ** tcf_pkg::TAB_FRAC));

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RUN  = 2'd1;
	localparam logic [1:0] C_FIN  = 2'd2;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic                    zero_q;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [Z_W-1:0]   z_q;
	logic signed [ACC_W-1:0] ang_q;

	logic signed [XY_W-1:0]  ax_e, az_e, x0, y0, x_ld, y_ld;
	logic signed [Z_W-1:0]   z_ld;
	logic signed [XY_W-1:0]  xs, ys, x_nx, y_nx;
	logic [tcf_pkg::TAB_W-1:0] tab;
	logic signed [Z_W-1:0]   tab_e, z_nx, z_rnd, z_clp;

	// Prescale and rotate a vector in the left half-plane by 90 degrees.
	always_comb begin
		ax_e = ax;
		az_e = az;
		x0   = az_e <<< tcf_pkg::PRESCALE_SH;
		y0   = -(ax_e <<< tcf_pkg::PRESCALE_SH);
		x_ld = x0;
		y_ld = y0;
		z_ld = '0;
		if (x0[XY_W-1]) begin
			if (!y0[XY_W-1]) begin
				x_ld = y0;
				y_ld = -x0;
				z_ld = Z_QUAD;
			end else begin
				x_ld = -y0;
				y_ld = x0;
				z_ld = -Z_QUAD;
			end
		end
	end

	always_comb begin
		xs    = x_q >>> cnt_q;
		ys    = y_q >>> cnt_q;
		tab   = tcf_pkg::atan_deg(tcf_pkg::TAB_IDX_W'(cnt_q));
		tab_e = {{(Z_W - tcf_pkg::TAB_W){1'b0}}, tab};
		if (!y_q[XY_W-1]) begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + tab_e;
		end else begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - tab_e;
		end
	end

	// Round to FRAC_BITS with ties toward plus infinity, then clamp to +-180 degrees.
	always_comb begin
		z_rnd = (z_q + Z_ROUND) >>> SH_OUT;
		if (z_rnd > Z_LIM) begin
			z_clp = Z_LIM;
		end else if (z_rnd < -Z_LIM) begin
			z_clp = -Z_LIM;
		end else begin
			z_clp = z_rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS_EFF - 1)) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			x_q    <= x_ld;
			y_q    <= y_ld;
			z_q    <= z_ld;
			zero_q <= (ax == '0) && (az == '0);
		end else if (state_q == C_RUN) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (state_q == C_FIN) begin
			ang_q <= zero_q ? '0 : ACC_W'(z_clp);
		end
	end

	assign done  = done_q;
	assign angle = ang_q;

endmodule

// ===== hw/rtl/tcf_cdiv.sv =====
// Signed division by a constant, rounded to nearest with ties away from zero.
// Digit-serial long division, DIGIT_BITS quotient bits per cycle; no package needed.
module tcf_cdiv #(
	parameter int NUM_W      = 36,
	parameter int DIVISOR    = 50,
	parameter int DIGIT_BITS = 4,
	parameter int STEPS      = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [NUM_W-1:0]                num,
	output logic                                   done,
	output logic signed [STEPS*DIGIT_BITS:0]       quo
);

	localparam int MAG_W = NUM_W + 1;
	localparam int DLOG  = $clog2(DIVISOR + 1) - 1;
	localparam int Q_W   = STEPS * DIGIT_BITS;
	localparam int EXT_W = DLOG + Q_W;
	localparam int R_W   = DLOG + 1;
	localparam int RS_W  = R_W + DIGIT_BITS;
	localparam int CNT_W = $clog2(STEPS);
	localparam int HALF  = DIVISOR / 2;
	localparam int RADIX = 2 ** DIGIT_BITS;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_PREP = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic                  neg_q;
	logic [NUM_W-1:0]      mag_q;
	logic [R_W-1:0]        rem_q;
	logic [Q_W-1:0]        sh_q;
	logic signed [Q_W:0]   quo_q;

	logic [EXT_W-1:0]      ext;
	logic [RS_W-1:0]       rs, sub;
	logic [DIGIT_BITS-1:0] dig;
	logic [R_W-1:0]        rem_nx;

	// The remainder stays below DIVISOR, so the top DLOG dividend bits seed it directly.
	assign ext = EXT_W'(mag_q) + EXT_W'(HALF);

	always_comb begin
		rs  = {rem_q, sh_q[Q_W-1 -: DIGIT_BITS]};
		dig = '0;
		sub = '0;
		for (int k = 1; k < RADIX; k++) begin
			if (rs >= RS_W'(k * DIVISOR)) begin
				dig = DIGIT_BITS'(k);
				sub = RS_W'(k * DIVISOR);
			end
		end
		rem_nx = R_W'(rs - sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_PREP;
					end
				end
				D_PREP: begin
					cnt_q   <= '0;
					state_q <= D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// The dividend shifts out of the top of sh_q while quotient digits shift in below.
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= num[NUM_W-1];
					mag_q <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
				end
			end
			D_PREP: begin
				rem_q <= R_W'(ext[EXT_W-1:Q_W]);
				sh_q  <= ext[Q_W-1:0];
			end
			D_RUN: begin
				rem_q <= rem_nx;
				sh_q  <= {sh_q[Q_W-DIGIT_BITS-1:0], dig};
			end
			D_FIN: begin
				quo_q <= neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
